[rtl/core/wso_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package wso_pkg;

	localparam int WORD_W   = 16;
	localparam int SCALE_W  = 20;
	localparam int COUNT_W  = 8;
	localparam int CFG_W    = 20;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_W    = 20;
	localparam int MODE_W   = 2;
	localparam int TAG_W    = 2;

	localparam int AVERAGE_DEPTH_DEF = 10;

	localparam logic [SCALE_W-1:0] SPEED_SCALE_RST    = 20'd98175;
	localparam logic [COUNT_W-1:0] EDGES_PER_STEP_RST = 8'd4;
	localparam logic [COUNT_W-1:0] STALL_TICKS_RST    = 8'd10;

	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EDGES_PER_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STALL_TICKS    = 2'd2;

	localparam logic [MODE_W-1:0] MODE_FINE_TICK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HALL_EDGE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SLOW_TICK = 2'd2;

	localparam logic [TAG_W-1:0] TAG_LEFT_SPEED  = 2'd0;
	localparam logic [TAG_W-1:0] TAG_RIGHT_SPEED = 2'd1;
	localparam logic [TAG_W-1:0] TAG_LEFT_DIST   = 2'd2;
	localparam logic [TAG_W-1:0] TAG_RIGHT_DIST  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_SPEED,
		ST_UPDATE,
		ST_DIV_MEAN,
		ST_EMIT0,
		ST_EMIT1
	} state_t;

endpackage
`default_nettype wire

[rtl/core/wso_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module wso_div import wso_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIV_W-1:0]  dividend,
	input  wire logic [WORD_W-1:0] divisor,
	output logic                   done,
	output logic [DIV_W-1:0]       quotient
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_W-1:0]  quo_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] dsr_q;
	logic [WORD_W+1:0] trial;

	// One quotient bit per cycle, restoring division.
	assign trial = {1'b0, rem_q, quo_q[DIV_W-1]} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[WORD_W+1]) begin
				rem_q <= trial[WORD_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[WORD_W-2:0], quo_q[DIV_W-1]};
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

[rtl/core/wheel_speed_odometer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Speed and distance of two wheels from hall-sensor edges.
// Input items (in_valid/in_ready, mode, wheel) carry a fine tick, a hall edge
// or a slow tick. Result items (out_valid/out_ready) carry message_tag,
// message_value and last, which marks the final result of an input item.
// The block works on one input item at a time. A fine tick, a slow tick
// without a report, an edge with a zero period and an ignored item are
// taken without leaving the idle state. A hall edge runs a 20-bit quotient
// through the shared bit-serial divider, one bit per cycle, and updates the
// speed ring. When a distance step is reached the ring mean goes through the
// same divider. A stall report goes from idle straight to the emit states.
// Results leave through an output register; the block accepts the next item
// while a result waits there, but it holds a second result of the same item
// until the receiver takes the first, so a stalled receiver stalls the block.
// Reset clears the timebase, the speed rings, all counters and the output,
// and loads the default configuration. The user must write configuration
// through cfg_we, cfg_index and cfg_data only while the block is idle; the
// block itself does not enforce it.
module wheel_speed_odometer_top import wso_pkg::*; #(
	parameter int AVERAGE_DEPTH = AVERAGE_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [MODE_W-1:0]    mode,
	input  wire logic                 wheel,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [TAG_W-1:0]          message_tag,
	output logic [WORD_W-1:0]         message_value,
	output logic                      last
);

	localparam int PTR_W = $clog2(AVERAGE_DEPTH);
	localparam int SUM_W = WORD_W + $clog2(AVERAGE_DEPTH);

	state_t state_q, state_nxt;

	logic [SCALE_W-1:0] scale_q;
	logic [COUNT_W-1:0] eps_q;
	logic [COUNT_W-1:0] stall_ticks_q;

	logic [WORD_W-1:0]  timebase_q;
	logic [WORD_W-1:0]  last_edge_q [2];
	logic [WORD_W-1:0]  hist_q [2][AVERAGE_DEPTH];
	logic [PTR_W-1:0]   ptr_q [2];
	logic [SUM_W-1:0]   sum_q [2];
	logic [COUNT_W-1:0] pres_q [2];
	logic [WORD_W-1:0]  dist_q [2];
	logic [COUNT_W-1:0] stall_q;

	logic               w_q;
	logic [WORD_W-1:0]  speed_q;
	logic [TAG_W-1:0]   res0_tag_q, res1_tag_q;
	logic [WORD_W-1:0]  res0_val_q, res1_val_q;

	logic               out_valid_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic [WORD_W-1:0]  out_val_q;
	logic               out_last_q;

	logic               in_acc;
	logic               out_free;
	logic               out_load;
	logic               div_start;
	logic               div_done;
	logic [DIV_W-1:0]   div_quo;
	logic [DIV_W-1:0]   div_dividend;
	logic [WORD_W-1:0]  div_divisor;

	logic [WORD_W-1:0]  period;
	logic [COUNT_W-1:0] stall_nxt;
	logic               stall_hit;
	logic [WORD_W-1:0]  old_speed;
	logic [SUM_W-1:0]   sum_new;
	logic [PTR_W-1:0]   ptr_nxt;
	logic [COUNT_W-1:0] pres_nxt;
	logic               emit_edge;
	logic [WORD_W-1:0]  speed_sat;

	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign period    = timebase_q - last_edge_q[wheel];
	assign stall_nxt = stall_q + COUNT_W'(1);
	assign stall_hit = stall_nxt >= stall_ticks_q;
	assign old_speed = hist_q[w_q][ptr_q[w_q]];
	assign sum_new   = sum_q[w_q] - SUM_W'(old_speed) + SUM_W'(speed_q);
	assign ptr_nxt   = (ptr_q[w_q] == PTR_W'(AVERAGE_DEPTH - 1)) ? '0
	                                                              : ptr_q[w_q] + PTR_W'(1);
	assign pres_nxt  = pres_q[w_q] + COUNT_W'(1);
	assign emit_edge = pres_nxt >= eps_q;
	assign speed_sat = (div_quo[DIV_W-1:WORD_W] != '0) ? '1 : div_quo[WORD_W-1:0];

	always_comb begin
		in_ready     = 1'b0;
		div_start    = 1'b0;
		out_load     = 1'b0;
		div_dividend = DIV_W'(SUM_W'(sum_new));
		div_divisor  = WORD_W'(AVERAGE_DEPTH);
		case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				div_start    = in_acc && (mode == MODE_HALL_EDGE) && (period != '0);
				div_dividend = DIV_W'(scale_q);
				div_divisor  = period;
			end
			ST_UPDATE: begin
				div_start = emit_edge;
			end
			ST_EMIT0, ST_EMIT1: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (div_start) begin
					state_nxt = ST_DIV_SPEED;
				end else if (in_acc && (mode == MODE_SLOW_TICK) && stall_hit) begin
					state_nxt = ST_EMIT0;
				end
			end
			ST_DIV_SPEED: begin
				if (div_done) begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_nxt = emit_edge ? ST_DIV_MEAN : ST_IDLE;
			end
			ST_DIV_MEAN: begin
				if (div_done) begin
					state_nxt = ST_EMIT0;
				end
			end
			ST_EMIT0: begin
				if (out_load) begin
					state_nxt = ST_EMIT1;
				end
			end
			ST_EMIT1: begin
				if (out_load) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	wso_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			scale_q       <= SPEED_SCALE_RST;
			eps_q         <= EDGES_PER_STEP_RST;
			stall_ticks_q <= STALL_TICKS_RST;
			timebase_q    <= '0;
			stall_q       <= '0;
			out_valid_q   <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				last_edge_q[i] <= '0;
				ptr_q[i]       <= '0;
				sum_q[i]       <= '0;
				pres_q[i]      <= '0;
				dist_q[i]      <= '0;
				for (int j = 0; j < AVERAGE_DEPTH; j++) begin
					hist_q[i][j] <= '0;
				end
			end
		end else begin
			state_q <= state_nxt;

			if (cfg_we) begin
				case (cfg_index)
					CFG_SPEED_SCALE:    scale_q       <= cfg_data[SCALE_W-1:0];
					CFG_EDGES_PER_STEP: eps_q         <= cfg_data[COUNT_W-1:0];
					CFG_STALL_TICKS:    stall_ticks_q <= cfg_data[COUNT_W-1:0];
					default: begin
					end
				endcase
			end

			if ((state_q == ST_IDLE) && in_acc) begin
				case (mode)
					MODE_FINE_TICK: begin
						timebase_q <= timebase_q + WORD_W'(1);
					end
					MODE_HALL_EDGE: begin
						stall_q            <= '0;
						last_edge_q[wheel] <= timebase_q;
					end
					MODE_SLOW_TICK: begin
						stall_q <= stall_hit ? '0 : stall_nxt;
					end
					default: begin
					end
				endcase
			end

			if (state_q == ST_UPDATE) begin
				hist_q[w_q][ptr_q[w_q]] <= speed_q;
				sum_q[w_q]              <= sum_new;
				ptr_q[w_q]              <= ptr_nxt;
				if (emit_edge) begin
					pres_q[w_q] <= '0;
					dist_q[w_q] <= dist_q[w_q] + WORD_W'(1);
				end else begin
					pres_q[w_q] <= pres_nxt;
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_acc) begin
			w_q        <= wheel;
			res0_tag_q <= TAG_RIGHT_SPEED;
			res0_val_q <= '0;
			res1_tag_q <= TAG_LEFT_SPEED;
			res1_val_q <= '0;
		end
		if ((state_q == ST_DIV_SPEED) && div_done) begin
			speed_q <= speed_sat;
		end
		if (state_q == ST_UPDATE) begin
			res0_tag_q <= w_q ? TAG_RIGHT_SPEED : TAG_LEFT_SPEED;
			res1_tag_q <= w_q ? TAG_RIGHT_DIST : TAG_LEFT_DIST;
			res1_val_q <= dist_q[w_q] + WORD_W'(1);
		end
		if ((state_q == ST_DIV_MEAN) && div_done) begin
			res0_val_q <= div_quo[WORD_W-1:0];
		end
		if (out_load) begin
			out_tag_q  <= (state_q == ST_EMIT0) ? res0_tag_q : res1_tag_q;
			out_val_q  <= (state_q == ST_EMIT0) ? res0_val_q : res1_val_q;
			out_last_q <= (state_q == ST_EMIT1);
		end
	end

	assign out_valid     = out_valid_q;
	assign message_tag   = out_tag_q;
	assign message_value = out_val_q;
	assign last          = out_last_q;

endmodule
`default_nettype wire
